// ===== hw/rtl/dllm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared widths, operation and status codes for the linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    localparam int ACT_W         = 3;
    localparam int IDX_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int SIZE_W        = 7;
    localparam int NUM_SLOTS_DEF = 64;

    typedef logic [ACT_W-1:0]    action_t;
    typedef logic [IDX_W-1:0]    index_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SIZE_W-1:0]   size_t;

    localparam action_t ACT_INS_HEAD = 3'd0;
    localparam action_t ACT_INS_TAIL = 3'd1;
    localparam action_t ACT_REM_HEAD = 3'd2;
    localparam action_t ACT_REM_TAIL = 3'd3;
    localparam action_t ACT_REM_NODE = 3'd4;

    localparam status_t STATUS_DONE   = 2'd0;
    localparam status_t STATUS_EMPTY  = 2'd1;
    localparam status_t STATUS_MISUSE = 2'd2;

endpackage

// ===== hw/rtl/dllm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_req_if
// Request channel: one list operation per transfer.
// ----------------------------------------------------------------------------
interface dllm_req_if import dllm_pkg::*;
();
    logic    valid;
    logic    ready;
    action_t action;
    index_t  node_index;

    modport source (output valid, output action, output node_index, input ready);
    modport sink   (input valid, input action, input node_index, output ready);
endinterface

// ===== hw/rtl/dllm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_rsp_if
// Response channel: one result per list operation.
// ----------------------------------------------------------------------------
interface dllm_rsp_if import dllm_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    index_t  removed_index;
    size_t   list_size;

    modport source (output valid, output status, output removed_index,
                    output list_size, input ready);
    modport sink   (input valid, input status, input removed_index,
                    input list_size, output ready);
endinterface

// ===== hw/rtl/dllm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/doubly_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_core
// Doubly linked list over a pool of node slots, links kept in two RAMs.
//
//   Channel  Dir  Payload                               Transfer when
//   req      in   action, node_index                    valid && ready
//   rsp      out  status, removed_index, list_size      valid && ready
//
// Inserts and rejected operations finish in the accepting state; removals
// add an ST_UNLINK state, needed because the link RAMs have a registered
// read port (read links, then patch the neighbors).
// Reset (rst_n, async) empties the list at once; link RAMs are not cleared.
// A stalled response holds off the next request until it transfers; a
// removal takes no new request while in ST_UNLINK.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_core import dllm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dllm_req_if.sink   req,
    dllm_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UNLINK = 1'b1;

    logic                 state_reg, state_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    tail_reg, tail_next;
    logic [LINK_W-1:0]    count_reg, count_next;
    logic [NUM_SLOTS-1:0] flag_reg, flag_next;
    logic [SLOT_W-1:0]    victim_reg, victim_next;
    logic                 head_hit_reg, head_hit_next;
    logic                 tail_hit_reg, tail_hit_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    index_t               out_removed_reg, out_removed_next;
    size_t                out_size_reg, out_size_next;

    logic              prev_we, next_we;
    logic [SLOT_W-1:0] prev_waddr, next_waddr;
    logic [LINK_W-1:0] prev_wdata, next_wdata;
    logic [SLOT_W-1:0] rd_addr;
    logic [LINK_W-1:0] prev_rdata, next_rdata;

    logic              accept;
    logic              is_empty;
    logic              node_ok;
    logic              node_linked;
    logic [SLOT_W-1:0] node_slot;
    logic [SLOT_W-1:0] head_slot, tail_slot;
    logic [SLOT_W-1:0] victim_slot;
    logic [LINK_W-1:0] p_link, n_link;
    logic              p_ok, n_ok;

    dllm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    dllm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign is_empty    = (count_reg == '0);
    assign node_ok     = (32'(req.node_index) < NUM_SLOTS);
    assign node_slot   = SLOT_W'(req.node_index);
    assign node_linked = node_ok && flag_reg[node_slot];
    assign head_slot   = head_reg[SLOT_W-1:0];
    assign tail_slot   = tail_reg[SLOT_W-1:0];

    always_comb
    begin
        case (req.action)
            ACT_REM_HEAD: victim_slot = head_slot;
            ACT_REM_TAIL: victim_slot = tail_slot;
            default:      victim_slot = node_slot;
        endcase
    end

    // Fetch the victim's links at the transfer edge; both RAMs share it.
    assign rd_addr = victim_slot;

    // The head has no predecessor and the tail no successor, whatever the RAM holds.
    assign p_link = head_hit_reg ? NULL_LINK : prev_rdata;
    assign n_link = tail_hit_reg ? NULL_LINK : next_rdata;
    assign p_ok   = (32'(p_link) < NUM_SLOTS);
    assign n_ok   = (32'(n_link) < NUM_SLOTS);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        flag_next        = flag_reg;
        victim_next      = victim_reg;
        head_hit_next    = head_hit_reg;
        tail_hit_next    = tail_hit_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_size_next    = out_size_reg;

        prev_we    = 1'b0;
        prev_waddr = node_slot;
        prev_wdata = NULL_LINK;
        next_we    = 1'b0;
        next_waddr = node_slot;
        next_wdata = NULL_LINK;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_removed_next = '0;
                    out_size_next    = SIZE_W'(count_reg);
                    case (req.action)
                        ACT_INS_HEAD, ACT_INS_TAIL:
                        begin
                            out_valid_next = 1'b1;
                            if (!node_ok || flag_reg[node_slot])
                            begin
                                out_status_next = STATUS_MISUSE;
                            end
                            else
                            begin
                                out_status_next = STATUS_DONE;
                                out_size_next   = SIZE_W'(count_reg + LINK_W'(1));
                                count_next      = count_reg + LINK_W'(1);
                                flag_next[node_slot] = 1'b1;
                                if (req.action == ACT_INS_HEAD)
                                begin
                                    next_we    = 1'b1;
                                    next_waddr = node_slot;
                                    next_wdata = head_reg;
                                    prev_we    = !is_empty;
                                    prev_waddr = head_slot;
                                    prev_wdata = LINK_W'(node_slot);
                                    head_next  = LINK_W'(node_slot);
                                    if (is_empty)
                                    begin
                                        tail_next = LINK_W'(node_slot);
                                    end
                                end
                                else
                                begin
                                    prev_we    = 1'b1;
                                    prev_waddr = node_slot;
                                    prev_wdata = tail_reg;
                                    next_we    = !is_empty;
                                    next_waddr = tail_slot;
                                    next_wdata = LINK_W'(node_slot);
                                    tail_next  = LINK_W'(node_slot);
                                    if (is_empty)
                                    begin
                                        head_next = LINK_W'(node_slot);
                                    end
                                end
                            end
                        end
                        ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_NODE:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                            end
                            else if (req.action == ACT_REM_NODE && !node_linked)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_MISUSE;
                            end
                            else
                            begin
                                victim_next   = victim_slot;
                                head_hit_next = (LINK_W'(victim_slot) == head_reg);
                                tail_hit_next = (LINK_W'(victim_slot) == tail_reg);
                                state_next    = ST_UNLINK;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_MISUSE;
                        end
                    endcase
                end
            end
            ST_UNLINK:
            begin
                // Patch the neighbors around the victim.
                next_we    = p_ok;
                next_waddr = p_link[SLOT_W-1:0];
                next_wdata = n_link;
                prev_we    = n_ok;
                prev_waddr = n_link[SLOT_W-1:0];
                prev_wdata = p_link;
                if (!p_ok)
                begin
                    head_next = n_link;
                end
                if (!n_ok)
                begin
                    tail_next = p_link;
                end
                if (count_reg <= LINK_W'(1))
                begin
                    head_next = NULL_LINK;
                    tail_next = NULL_LINK;
                end
                flag_next[victim_reg] = 1'b0;
                count_next       = count_reg - LINK_W'(1);
                out_valid_next   = 1'b1;
                out_status_next  = STATUS_DONE;
                out_removed_next = IDX_W'(victim_reg);
                out_size_next    = SIZE_W'(count_reg - LINK_W'(1));
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NULL_LINK;
            tail_reg      <= NULL_LINK;
            count_reg     <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg      <= victim_next;
        head_hit_reg    <= head_hit_next;
        tail_hit_reg    <= tail_hit_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_size_reg    <= out_size_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_index = out_removed_reg;
    assign rsp.list_size     = out_size_reg;

endmodule

// ===== hw/rtl/dllm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_checker
// Port-level checks on the list manager responses, bound to the top level.
// ----------------------------------------------------------------------------
module dllm_checker import dllm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input logic    clk,
    input logic    rst_n,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input status_t status,
    input index_t  removed_index,
    input size_t   list_size
);

    // Hold a stalled response.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(status) && $stable(removed_index) && $stable(list_size)))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_DONE || status == STATUS_EMPTY ||
                       status == STATUS_MISUSE))
        else $error("undefined status code");

    a_fail_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STATUS_DONE) |-> (removed_index == '0))
        else $error("failed operation reports a removed slot");

    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STATUS_EMPTY) |-> (list_size == '0))
        else $error("empty status with nonzero list size");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(list_size) <= NUM_SLOTS))
        else $error("list size beyond slot count");

endmodule

bind doubly_linked_list_manager_core dllm_checker #(.NUM_SLOTS(NUM_SLOTS)) u_dllm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .removed_index (rsp.removed_index),
    .list_size     (rsp.list_size)
);
